@@ rtl/core/sscfr_pkg.sv @@
`timescale 1ns / 1ps
package sscfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;
  localparam logic [BYTE_W-1:0] TICK_DIVIDE_RESET = 8'd5;

  // input command codes
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_HELD = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SENSOR = 2'd1,
    PH_COMM   = 2'd2
  } phase_t;

  // what the output register loads
  typedef enum logic [2:0] {
    OUT_SENSOR = 3'd0,
    OUT_COMM   = 3'd1,
    OUT_ERR    = 3'd2,
    OUT_OK     = 3'd3,
    OUT_PKT    = 3'd4
  } out_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_FETCH  = 3'd1,
    ST_SEND   = 3'd2,
    ST_HDR    = 3'd3,
    ST_PFETCH = 3'd4,
    ST_PSEND  = 3'd5
  } ctrl_state_t;

  typedef struct packed {
    logic     tick_inc;
    logic     tick_start;
    logic     held_wr;
    logic     sensor_wr;
    logic     reply_wr;
    logic     idx_inc;
    logic     idx_clr;
    logic     phase_set;
    phase_t   phase_val;
    logic     sum_clr;
    logic     sum_add;
    logic     rd_sensor;
    logic     rd_zero;
    logic     rd_reply;
    logic     rd_adv;
    logic     out_load;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   idx_last;
    logic   tick_hit;
    logic   sum_ok;
  } dp_stat_t;

endpackage

@@ rtl/core/sscfr_ram.sv @@
`timescale 1ns / 1ps
module sscfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sscfr_dp.sv @@
`timescale 1ns / 1ps
module sscfr_dp #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [sscfr_pkg::BYTE_W-1:0]              cfg_wdata,
  input  logic [sscfr_pkg::BYTE_W-1:0]              rx_byte,
  input  sscfr_pkg::dp_cmd_t                        cmd,
  output sscfr_pkg::dp_stat_t                       stat,
  output logic [sscfr_pkg::M_TDATA_W-1:0]           m_tdata,
  output logic                                      m_tuser,
  output logic                                      m_tlast
);
  import sscfr_pkg::*;

  localparam int IW = $clog2(FRAME_BYTES);
  localparam logic [IW-1:0] HELD_SLOT = IW'(FRAME_BYTES - 2);
  localparam logic [IW-1:0] LAST_SLOT = IW'(FRAME_BYTES - 1);

  logic [BYTE_W-1:0] tick_divide;
  logic [BYTE_W-1:0] tick_count;
  logic [BYTE_W-1:0] tick_count_next;
  phase_t            phase;
  logic [IW-1:0]     byte_index;
  logic [IW-1:0]     idx_plus;
  logic [BYTE_W-1:0] held;
  logic [BYTE_W-1:0] sum;
  logic              rd_held;

  logic [IW-1:0]     sensor_raddr;
  logic [IW-1:0]     reply_raddr;
  logic [BYTE_W-1:0] sensor_q;
  logic [BYTE_W-1:0] reply_q;
  logic [BYTE_W-1:0] tx_fetched;

  // output register
  logic              o_kind;
  logic              o_tx_valid;
  logic [BYTE_W-1:0] o_tx_byte;
  logic              o_sel_sensor;
  logic              o_sel_comm;
  logic              o_perr;
  logic [BYTE_W-1:0] o_pbyte;
  logic              o_last;

  assign tick_count_next = tick_count + 8'd1;
  assign idx_plus        = byte_index + IW'(1);
  assign sensor_raddr    = cmd.rd_zero ? '0 : idx_plus;
  assign reply_raddr     = cmd.rd_adv ? idx_plus : byte_index;
  assign tx_fetched      = rd_held ? held : sensor_q;

  assign stat.phase    = phase;
  assign stat.idx_last = (byte_index == LAST_SLOT);
  assign stat.tick_hit = (tick_count_next >= tick_divide);
  assign stat.sum_ok   = (sum == rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divide <= TICK_DIVIDE_RESET;
    end else if (cfg_we) begin
      tick_divide <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      phase      <= PH_IDLE;
      byte_index <= '0;
      held       <= '0;
      sum        <= '0;
    end else begin
      if (cmd.tick_start) begin
        tick_count <= '0;
        phase      <= PH_SENSOR;
        byte_index <= '0;
      end else begin
        if (cmd.tick_inc) begin
          tick_count <= tick_count_next;
        end
        if (cmd.phase_set) begin
          phase <= cmd.phase_val;
        end
        if (cmd.idx_clr) begin
          byte_index <= '0;
        end else if (cmd.idx_inc) begin
          byte_index <= idx_plus;
        end
      end
      if (cmd.held_wr) begin
        held <= rx_byte;
      end
      if (cmd.sum_clr) begin
        sum <= '0;
      end else if (cmd.sum_add) begin
        sum <= sum + rx_byte;
      end
    end
  end

  // the held slot lives in its own register; its RAM slot is never written and the RAM data is not used
  always_ff @(posedge clk) begin
    if (cmd.rd_sensor) begin
      rd_held <= (sensor_raddr == HELD_SLOT);
    end
  end

  sscfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_BYTES)
  ) u_sensor_ram (
    .clk   (clk),
    .we    (cmd.sensor_wr && (byte_index != HELD_SLOT)),
    .waddr (byte_index),
    .wdata (rx_byte),
    .re    (cmd.rd_sensor),
    .raddr (sensor_raddr),
    .rdata (sensor_q)
  );

  sscfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_BYTES)
  ) u_reply_ram (
    .clk   (clk),
    .we    (cmd.reply_wr),
    .waddr (byte_index),
    .wdata (rx_byte),
    .re    (cmd.rd_reply),
    .raddr (reply_raddr),
    .rdata (reply_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_kind       <= 1'b0;
      o_tx_valid   <= 1'b0;
      o_tx_byte    <= '0;
      o_sel_sensor <= 1'b0;
      o_sel_comm   <= 1'b0;
      o_perr       <= 1'b0;
      o_pbyte      <= '0;
      o_last       <= 1'b1;
      case (cmd.out_sel)
        OUT_SENSOR: begin
          o_tx_valid   <= 1'b1;
          o_sel_sensor <= 1'b1;
        end
        OUT_COMM: begin
          o_tx_valid <= 1'b1;
          o_tx_byte  <= tx_fetched;
          o_sel_comm <= 1'b1;
        end
        OUT_ERR: begin
          o_perr <= 1'b1;
        end
        OUT_OK: begin
          o_last <= 1'b0;
        end
        OUT_PKT: begin
          o_kind  <= 1'b1;
          o_pbyte <= reply_q;
          o_last  <= stat.idx_last;
        end
        default: begin
          o_last <= 1'b1;
        end
      endcase
    end
  end

  assign m_tdata = {4'd0, o_pbyte, o_perr, o_sel_comm, o_sel_sensor, o_tx_byte, o_tx_valid};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

endmodule

@@ rtl/core/sscfr_ctrl.sv @@
`timescale 1ns / 1ps
module sscfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sscfr_pkg::cmd_t     command,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  sscfr_pkg::dp_stat_t stat,
  output sscfr_pkg::dp_cmd_t  cmd
);
  import sscfr_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        take;

  assign take = s_tvalid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          case (command)
            CMD_TICK: begin
              if (stat.tick_hit) begin
                state_next = ST_SEND;
              end
            end
            CMD_BYTE: begin
              case (stat.phase)
                PH_SENSOR: state_next = stat.idx_last ? ST_FETCH : ST_SEND;
                PH_COMM: begin
                  if (!stat.idx_last) begin
                    state_next = ST_FETCH;
                  end else begin
                    state_next = stat.sum_ok ? ST_HDR : ST_SEND;
                  end
                end
                default: state_next = ST_IDLE;
              endcase
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_FETCH:  state_next = ST_SEND;
      ST_SEND:   state_next = m_tready ? ST_IDLE : ST_SEND;
      ST_HDR:    state_next = m_tready ? ST_PFETCH : ST_HDR;
      ST_PFETCH: state_next = ST_PSEND;
      ST_PSEND: begin
        if (m_tready) begin
          state_next = stat.idx_last ? ST_IDLE : ST_PFETCH;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.phase_val = PH_IDLE;
    cmd.out_sel   = OUT_SENSOR;
    s_tready      = (state == ST_IDLE);
    m_tvalid      = (state == ST_SEND) || (state == ST_HDR) || (state == ST_PSEND);
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          case (command)
            CMD_TICK: begin
              if (stat.tick_hit) begin
                cmd.tick_start = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.out_sel    = OUT_SENSOR;
              end else begin
                cmd.tick_inc = 1'b1;
              end
            end
            CMD_HELD: cmd.held_wr = 1'b1;
            CMD_BYTE: begin
              case (stat.phase)
                PH_SENSOR: begin
                  cmd.sensor_wr = 1'b1;
                  if (!stat.idx_last) begin
                    cmd.idx_inc  = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_SENSOR;
                  end else begin
                    // switch to the comm unit, fetch frame byte 0
                    cmd.idx_clr   = 1'b1;
                    cmd.phase_set = 1'b1;
                    cmd.phase_val = PH_COMM;
                    cmd.sum_clr   = 1'b1;
                    cmd.rd_sensor = 1'b1;
                    cmd.rd_zero   = 1'b1;
                  end
                end
                PH_COMM: begin
                  cmd.reply_wr = 1'b1;
                  if (!stat.idx_last) begin
                    cmd.sum_add   = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    cmd.rd_sensor = 1'b1;
                  end else begin
                    cmd.idx_clr   = 1'b1;
                    cmd.phase_set = 1'b1;
                    cmd.phase_val = PH_IDLE;
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = stat.sum_ok ? OUT_OK : OUT_ERR;
                  end
                end
                default: cmd.out_load = 1'b0;
              endcase
            end
            default: cmd.out_load = 1'b0;
          endcase
        end
      end
      ST_FETCH: begin
        cmd.out_load = 1'b1;
        cmd.out_sel  = OUT_COMM;
      end
      ST_SEND: cmd.out_load = 1'b0;
      ST_HDR: begin
        cmd.rd_reply = m_tready;
      end
      ST_PFETCH: begin
        cmd.out_load = 1'b1;
        cmd.out_sel  = OUT_PKT;
      end
      ST_PSEND: begin
        if (m_tready) begin
          if (stat.idx_last) begin
            cmd.idx_clr = 1'b1;
          end else begin
            // advance and prefetch the next reply byte
            cmd.idx_inc  = 1'b1;
            cmd.rd_reply = 1'b1;
            cmd.rd_adv   = 1'b1;
          end
        end
      end
      default: cmd.out_load = 1'b0;
    endcase
  end

endmodule

@@ rtl/core/spi_sensor_to_comm_frame_relay.sv @@
`timescale 1ns / 1ps
// Event-driven SPI master relay. Beats on s_* are timer ticks, SPI byte
// completions and writes of the held status byte; every tick_divide ticks a
// frame of FRAME_BYTES bytes is read from the sensor (the held byte replaces
// slot FRAME_BYTES-2), then sent to the comm unit while its reply comes in.
// A reply with a good 8-bit checksum is emitted as a header beat plus
// FRAME_BYTES packet beats (m_tuser high); a bad one gives one error beat.
// Each run of beats on m_* answers one input beat, and m_tlast marks the end
// of the run. One item is handled at a time: a held-byte write, an ignored
// beat or a tick that starts no frame is handled in the idle state; a
// frame-starting tick or a byte completion holds its beat in a send state
// until m_* takes it, after a fetch state when the next frame byte is read
// from the sensor frame RAM (registered read). A valid reply run sends its
// header, then a fetch and a send state per packet byte (registered reply RAM).
module spi_sensor_to_comm_frame_relay #(
  parameter int FRAME_BYTES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [7:0]                        cfg_wdata,  // tick_divide
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sscfr_pkg::S_TDATA_W-1:0]   s_tdata,    // command[1:0], rx_byte[9:2],
                                                        // zero pad
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sscfr_pkg::M_TDATA_W-1:0]   m_tdata,    // tx_valid[0], tx_byte[8:1],
                                                        // select_sensor[9],
                                                        // select_comm[10],
                                                        // packet_error[11],
                                                        // packet_byte[19:12], zero pad
  output logic                              m_tuser,    // kind
  output logic                              m_tlast     // last
);
  import sscfr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sscfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (cmd_t'(s_tdata[1:0])),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sscfr_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rx_byte   (s_tdata[9:2]),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import sscfr_pkg::*;

  localparam int FRAME_BYTES = 16;
  localparam int HELD_SLOT = FRAME_BYTES - 2;
  localparam int LAST_SLOT = FRAME_BYTES - 1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int QUIET_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_PHASES = 5;
  localparam int SHORT_BYTES = 3;

  typedef struct packed {
    logic       kind;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       sel_sensor;
    logic       sel_comm;
    logic       pkt_err;
    logic [7:0] pkt_byte;
    logic       last;
  } relay_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  spi_sensor_to_comm_frame_relay #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the relay state
  logic [7:0]  tick_div;
  logic [7:0]  tick_cnt;
  phase_t      bus_phase;
  logic [3:0]  byte_idx;
  logic [7:0]  sensor_frame [FRAME_BYTES];
  logic [7:0]  reply_frame [FRAME_BYTES];
  relay_beat_t relay_beats_due [$];

  // stimulus side
  logic [15:0] spi_events [$];
  logic [7:0]  gen_div;
  logic [7:0]  gen_ticks;
  bit          gen_started;
  int unsigned src_idle_pct = 0;
  int unsigned dst_stall_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  function automatic relay_beat_t bus_beat(input logic txv, input logic [7:0] txb,
                                           input logic ss, input logic sc,
                                           input logic err, input logic last);
    return {1'b0, txv, txb, ss, sc, err, 8'h00, last};
  endfunction

  task automatic relay_step(input logic [15:0] beat);
    logic [1:0] cmd;
    logic [7:0] rx;
    logic [7:0] sum;
    int idx;
    cmd = beat[1:0];
    rx = beat[9:2];
    idx = int'(byte_idx);
    case (cmd)
      CMD_TICK: begin
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= tick_div) begin
          tick_cnt = 8'd0;
          byte_idx = 4'd0;
          bus_phase = PH_SENSOR;
          relay_beats_due.push_back(bus_beat(1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1));
        end
      end
      CMD_HELD: sensor_frame[HELD_SLOT] = rx;
      CMD_BYTE: begin
        if (bus_phase == PH_SENSOR) begin
          // the held slot keeps the status byte
          if (idx != HELD_SLOT) sensor_frame[idx] = rx;
          if (idx < LAST_SLOT) begin
            byte_idx = byte_idx + 4'd1;
            relay_beats_due.push_back(bus_beat(1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1));
          end else begin
            byte_idx = 4'd0;
            bus_phase = PH_COMM;
            relay_beats_due.push_back(bus_beat(1'b1, sensor_frame[0], 1'b0, 1'b1, 1'b0,
                                               1'b1));
          end
        end else if (bus_phase == PH_COMM) begin
          reply_frame[idx] = rx;
          if (idx < LAST_SLOT) begin
            byte_idx = byte_idx + 4'd1;
            relay_beats_due.push_back(bus_beat(1'b1, sensor_frame[idx + 1], 1'b0, 1'b1,
                                               1'b0, 1'b1));
          end else begin
            byte_idx = 4'd0;
            bus_phase = PH_IDLE;
            sum = 8'h00;
            for (int i = 0; i < LAST_SLOT; i++) sum = sum + reply_frame[i];
            if (sum != reply_frame[LAST_SLOT]) begin
              relay_beats_due.push_back(bus_beat(1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
            end else begin
              relay_beats_due.push_back(bus_beat(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
              for (int i = 0; i < FRAME_BYTES; i++)
                relay_beats_due.push_back({1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0,
                                           reply_frame[i], i == LAST_SLOT});
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_beat(input string what, input relay_beat_t want,
                             input relay_beat_t seen);
    if (mismatches < MAX_REPORTS)
      $display("%s: want kind %0d txv %0d txb %02h ss %0d sc %0d err %0d pkt %02h last %0d",
               what, want.kind, want.tx_valid, want.tx_byte, want.sel_sensor,
               want.sel_comm, want.pkt_err, want.pkt_byte, want.last,
               " | got kind %0d txv %0d txb %02h ss %0d sc %0d err %0d pkt %02h last %0d",
               seen.kind, seen.tx_valid, seen.tx_byte, seen.sel_sensor, seen.sel_comm,
               seen.pkt_err, seen.pkt_byte, seen.last, " pad %h", m_tdata[23:20]);
    mismatches++;
  endtask

  // queue one event and track the tick count to know when a frame starts
  task automatic queue_event(input logic [1:0] cmd, input logic [7:0] rx);
    spi_events.push_back({6'b0, rx, cmd});
    gen_started = 1'b0;
    if (cmd == CMD_TICK) begin
      gen_ticks = gen_ticks + 8'd1;
      if (gen_ticks >= gen_div) begin
        gen_ticks = 8'd0;
        gen_started = 1'b1;
      end
    end
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic gen_frame(input bit good, input int n_bytes);
    int stray_at;
    int k;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] skew;
    stray_at = ($urandom_range(9) == 0) ? int'($urandom_range(n_bytes - 1)) : -1;
    // stray completions and unused codes ahead of the start
    repeat ($urandom_range(2)) queue_event(CMD_BYTE, 8'($urandom));
    if ($urandom_range(3) == 0) queue_event(CMD_UNUSED, 8'($urandom));
    do queue_event(CMD_TICK, 8'($urandom)); while (!gen_started);
    sum = 8'h00;
    for (k = 0; k < n_bytes; k++) begin
      if (k == stray_at) queue_event(CMD_TICK, 8'($urandom));
      if ($urandom_range(15) == 0) queue_event(CMD_HELD, rand_byte());
      if ($urandom_range(31) == 0) queue_event(CMD_UNUSED, 8'($urandom));
      if (k < FRAME_BYTES) begin
        b = rand_byte();
      end else if (k < 2 * FRAME_BYTES - 1) begin
        b = rand_byte();
        sum = sum + b;
      end else begin
        skew = 8'($urandom_range(1, 255));
        b = good ? sum : sum + skew;
      end
      queue_event(CMD_BYTE, b);
    end
  endtask

  task automatic settle();
    do @(negedge clk);
    while (spi_events.size() != 0 || s_tvalid || relay_beats_due.size() != 0);
    // ticks that start nothing leave no trace; give them time to retire
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_divide(input logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_div = value;
    gen_div = value;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (spi_events.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= spi_events.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= !rst && ($urandom_range(99) >= dst_stall_pct);
  end

  always @(posedge clk) begin : beat_monitor
    relay_beat_t seen;
    relay_beat_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen = {m_tuser, m_tdata[0], m_tdata[8:1], m_tdata[9], m_tdata[10], m_tdata[11],
                m_tdata[19:12], m_tlast};
        if (relay_beats_due.size() == 0) begin
          report_beat("unexpected beat", '0, seen);
        end else begin
          want = relay_beats_due.pop_front();
          if (seen !== want || m_tdata[23:20] !== 4'h0) report_beat("mismatch", want, seen);
        end
      end
      // predict after checking so a beat never meets its own expectation
      if (s_tvalid && s_tready) relay_step(s_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] phase_div [NUM_PHASES];
    int unsigned phase_src [NUM_PHASES];
    int unsigned phase_dst [NUM_PHASES];
    for (int i = 0; i < FRAME_BYTES; i++) begin
      sensor_frame[i] = 8'h00;
      reply_frame[i] = 8'h00;
    end
    tick_div = TICK_DIVIDE_RESET;
    tick_cnt = 8'd0;
    bus_phase = PH_IDLE;
    byte_idx = 4'd0;
    gen_div = TICK_DIVIDE_RESET;
    gen_ticks = 8'd0;
    phase_div = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd0};
    phase_div[4] = 8'($urandom_range(2, 6));
    phase_src = '{67, 0, 23, 0, 23};
    phase_dst = '{0, 67, 23, 0, 23};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: ignored events, held byte, start, restart mid-frame
    queue_event(CMD_BYTE, 8'h5A);
    queue_event(CMD_UNUSED, 8'hFF);
    queue_event(CMD_HELD, 8'hFF);
    repeat (5) queue_event(CMD_TICK, 8'h00);
    queue_event(CMD_BYTE, 8'hFF);
    queue_event(CMD_BYTE, 8'h00);
    queue_event(CMD_HELD, 8'h00);
    queue_event(CMD_UNUSED, 8'h00);
    repeat (5) queue_event(CMD_TICK, 8'hFF);
    queue_event(CMD_BYTE, 8'h00);
    queue_event(CMD_BYTE, 8'hFF);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_divide(phase_div[ph]);
      src_idle_pct = phase_src[ph];
      dst_stall_pct = phase_dst[ph];
      // a bad reply, then a good one under receiver stalls; later phases cut the
      // sensor read short
      if (ph < 2) gen_frame(ph == 1, 2 * FRAME_BYTES);
      else gen_frame(1'b1, SHORT_BYTES);
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (relay_beats_due.size() != 0) begin
      if (mismatches < MAX_REPORTS)
        $display("%0d expected beats never arrived", relay_beats_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ spi_sensor_to_comm_frame_relay.f @@
rtl/core/sscfr_pkg.sv
rtl/core/sscfr_ram.sv
rtl/core/sscfr_dp.sv
rtl/core/sscfr_ctrl.sv
rtl/core/spi_sensor_to_comm_frame_relay.sv
bench/testbench.sv
